FILE: rtl/first_fit_block_allocator_unit_assert.svh
// assertion macros for the first-fit allocator
// no dependencies
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
// property that must hold at every edge outside reset
`define FFA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define FFA_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

FILE: rtl/ffa_pkg.sv
// package for the first-fit allocator: sizes, codes and state type
// no dependencies
package ffa_pkg;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_BLOCKS   = 4096;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_REM_RD,
        S_REM_WR,
        S_STAT_RD,
        S_STAT_CHK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] granted_offset;
        logic [12:0] used_count;
        logic [15:0] used_bytes;
        logic [15:0] largest_free;
    } result_t;

    // data size of a block from its offset and the next header or arena end
    function automatic logic [15:0] gap(input logic [16:0] nxt, input logic [15:0] off);
        logic [17:0] d;
        d = {1'b0, nxt} - {2'b0, off};
        gap = d[17] ? 16'd0 : d[15:0];
    endfunction
endpackage

FILE: rtl/ffa_if.sv
// valid/ready channel interfaces for the allocator
// no dependencies
interface ffa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] request_size;
    logic [15:0] block_offset;
    modport source (output valid, opcode, request_size, block_offset, input ready);
    modport sink (input valid, opcode, request_size, block_offset, output ready);
endinterface

interface ffa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] granted_offset;
    logic [12:0] used_count;
    logic [15:0] used_bytes;
    logic [15:0] largest_free;
    modport source (output valid, status, granted_offset, used_count, used_bytes,
                    largest_free, input ready);
    modport sink (input valid, status, granted_offset, used_count, used_bytes,
                  largest_free, output ready);
endinterface

FILE: rtl/ffa_table.sv
// block table memory: offset and free flag per entry, one write and one read port
// depends on ffa_pkg
module ffa_table
    import ffa_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [16:0]      wdata,
    input  logic [IDX_W-1:0] raddr,
    output logic [16:0]      rdata
);
    logic [16:0] mem [MAX_BLOCKS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/first_fit_block_allocator_unit.sv
// top level of the first-fit allocator: sequencer over the block table
// depends on ffa_pkg, ffa_if, ffa_table and the assertion header
`include "first_fit_block_allocator_unit_assert.svh"

// One operation at a time. Each beat walks the table in address order, reading
// one entry at a time through the table's read port: the search visits entries
// until it finds a fit or a match, a split or merge then shifts the tail entry
// by entry, and the statistics pass visits every one of the N blocks in the
// table (up to 4096).
// Init resets the table by writing entry zero and setting the count to one. After
// reset, ready stays low for one cycle while entry zero is loaded.
module first_fit_block_allocator_unit
    import ffa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    ffa_req_if.sink     req,
    ffa_rsp_if.source   rsp
);
    state_t state_reg, state_next;
    logic [15:0] arena_cfg_reg, arena_size_reg, arena_size_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [1:0]  op_reg, op_next;
    logic [15:0] req_reg, req_next, boff_reg, boff_next;
    // current entry held while walking (the previous entry's free flag is kept in pfree_reg)
    logic [16:0] cur_reg, cur_next, prv_reg, prv_next;
    logic        have_cur_reg, have_cur_next;
    logic        pfree_reg, pfree_next;
    logic [16:0] carry_reg, carry_next;
    logic        rm2_reg, rm2_next;
    logic        boot_reg, boot_next;
    result_t     res_reg, res_next;
    logic [16:0] acc_bytes_reg, acc_bytes_next;
    logic        we;
    logic [IDX_W-1:0] waddr, raddr;
    logic [16:0] wdata, rdata;

    ffa_table u_table (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            arena_cfg_reg  <= 16'd4096;
            arena_size_reg <= 16'd4096;
            count_reg      <= CNT_W'(1);
            have_cur_reg   <= 1'b0;
            boot_reg       <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            arena_size_reg <= arena_size_next;
            count_reg      <= count_next;
            have_cur_reg   <= have_cur_next;
            boot_reg       <= boot_next;
            if (cfg_we)
            begin
                arena_cfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next; j_reg <= j_next; op_reg <= op_next;
        req_reg <= req_next; boff_reg <= boff_next;
        cur_reg <= cur_next; prv_reg <= prv_next; pfree_reg <= pfree_next;
        carry_reg <= carry_next;
        rm2_reg <= rm2_next; res_reg <= res_next; acc_bytes_reg <= acc_bytes_next;
    end

    // block size of the entry held in cur_reg, given the next entry (or arena end)
    logic [16:0] nxt_hdr;
    logic [15:0] bsz;
    logic        last;
    logic [17:0] need;
    logic [16:0] used_sum;

    always_comb
    begin
        state_next = state_reg; arena_size_next = arena_size_reg; count_next = count_reg;
        i_next = i_reg; j_next = j_reg; op_next = op_reg; req_next = req_reg;
        boff_next = boff_reg; cur_next = cur_reg; prv_next = prv_reg;
        pfree_next = pfree_reg; carry_next = carry_reg;
        rm2_next = rm2_reg; res_next = res_reg; boot_next = boot_reg;
        acc_bytes_next = acc_bytes_reg; have_cur_next = have_cur_reg;
        we = 1'b0; waddr = '0; wdata = '0; raddr = i_reg[IDX_W-1:0];
        req.ready = 1'b0;
        rsp.valid = 1'b0;
        last = 1'b0; nxt_hdr = '0; bsz = '0; need = '0; used_sum = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (boot_reg)
                begin
                    // load the single free block left by reset
                    we = 1'b1; waddr = '0;
                    wdata = {1'b1, 16'(HEADER_BYTES)};
                    boot_next = 1'b0;
                end
                else
                begin
                    req.ready = 1'b1;
                    if (req.valid)
                    begin
                        op_next = req.opcode; req_next = req.request_size;
                        boff_next = req.block_offset;
                        res_next = '0; i_next = '0; have_cur_next = 1'b0;
                        pfree_next = 1'b0;
                        case (req.opcode)
                            OP_INIT:
                            begin
                                arena_size_next = arena_cfg_reg;
                                count_next = CNT_W'(1);
                                we = 1'b1; waddr = '0;
                                wdata = {1'b1, 16'(HEADER_BYTES)};
                                state_next = S_STAT_RD;
                            end
                            OP_ALLOC:
                            begin
                                res_next.status = ST_NO_FIT;
                                state_next = S_SRCH_RD;
                            end
                            OP_FREE:
                            begin
                                res_next.status = ST_NOT_FOUND;
                                state_next = S_SRCH_RD;
                            end
                            default: state_next = S_STAT_RD;
                        endcase
                    end
                end
            end
            S_SRCH_RD:
            begin
                // read entry i (next of cur); when i reaches count, search ends
                raddr = i_reg[IDX_W-1:0];
                if (i_reg >= count_reg && !have_cur_reg)
                begin
                    i_next = '0; state_next = S_STAT_RD;
                end
                else
                begin
                    state_next = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK:
            begin
                last = (i_reg >= count_reg);
                nxt_hdr = last ? {1'b0, arena_size_reg}
                               : {1'b0, rdata[15:0]} - 17'(HEADER_BYTES);
                bsz = gap(nxt_hdr, cur_reg[15:0]);
                need = {2'b0, req_reg} + 18'(HEADER_BYTES);
                if (!have_cur_reg)
                begin
                    cur_next = rdata; have_cur_next = 1'b1;
                    i_next = i_reg + 1'b1;
                    state_next = S_SRCH_RD;
                end
                else if (op_reg == OP_ALLOC && cur_reg[16] && bsz >= req_reg)
                begin
                    // entry index i-1 is cur
                    res_next.status = ST_OK;
                    res_next.granted_offset = cur_reg[15:0];
                    we = 1'b1; waddr = IDX_W'(i_reg - 1'b1);
                    wdata = {1'b0, cur_reg[15:0]};
                    if ({2'b0, bsz} > need && count_reg < CNT_W'(MAX_BLOCKS))
                    begin
                        carry_next = {1'b1, cur_reg[15:0] + req_reg + 16'(HEADER_BYTES)};
                        j_next = i_reg;
                        count_next = count_reg + 1'b1;
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        i_next = '0; state_next = S_STAT_RD;
                    end
                end
                else if (op_reg == OP_FREE && cur_reg[15:0] == boff_reg)
                begin
                    res_next.status = ST_OK;
                    rm2_next = !last && rdata[16];
                    if (pfree_reg)
                    begin
                        // drop cur (and right if free); left already free
                        count_next = count_reg - (!last && rdata[16] ? 2'd2 : 2'd1);
                    end
                    else
                    begin
                        we = 1'b1; waddr = IDX_W'(i_reg - 1'b1);
                        wdata = {1'b1, cur_reg[15:0]};
                        count_next = count_reg - (!last && rdata[16] ? 2'd1 : 2'd0);
                    end
                    if (!last && rdata[16] || pfree_reg)
                    begin
                        j_next = pfree_reg ? i_reg - 1'b1 : i_reg;
                        state_next = S_REM_RD;
                    end
                    else
                    begin
                        i_next = '0; state_next = S_STAT_RD;
                    end
                end
                else if (last)
                begin
                    i_next = '0; have_cur_next = 1'b0; state_next = S_STAT_RD;
                end
                else
                begin
                    pfree_next = cur_reg[16]; cur_next = rdata;
                    i_next = i_reg + 1'b1; state_next = S_SRCH_RD;
                end
            end
            S_SHIFT_RD:
            begin
                // insert carry at j, pushing old contents up by one
                raddr = j_reg[IDX_W-1:0];
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                we = 1'b1; waddr = j_reg[IDX_W-1:0]; wdata = carry_reg;
                carry_next = rdata;
                j_next = j_reg + 1'b1;
                if (j_reg + 1'b1 >= count_reg)
                begin
                    i_next = '0; state_next = S_STAT_RD;
                end
                else
                begin
                    state_next = S_SHIFT_RD;
                end
            end
            S_REM_RD:
            begin
                // copy from j + gap down to j, gap is one or two entries
                raddr = IDX_W'(j_reg + ((rm2_reg && pfree_reg) ? 2'd2 : 2'd1));
                if (j_reg >= count_reg)
                begin
                    i_next = '0; state_next = S_STAT_RD;
                end
                else
                begin
                    state_next = S_REM_WR;
                end
            end
            S_REM_WR:
            begin
                we = 1'b1; waddr = j_reg[IDX_W-1:0]; wdata = rdata;
                j_next = j_reg + 1'b1;
                state_next = S_REM_RD;
            end
            S_STAT_RD:
            begin
                raddr = i_reg[IDX_W-1:0];
                if (i_reg == '0)
                begin
                    acc_bytes_next = '0; res_next.used_count = '0;
                    res_next.largest_free = '0; have_cur_next = 1'b0;
                end
                state_next = S_STAT_CHK;
            end
            S_STAT_CHK:
            begin
                // cur holds entry i-1, rdata is entry i (or past the end)
                last = (i_reg >= count_reg);
                if (have_cur_reg)
                begin
                    nxt_hdr = last ? {1'b0, arena_size_reg}
                                   : {1'b0, rdata[15:0]} - 17'(HEADER_BYTES);
                    bsz = gap(nxt_hdr, cur_reg[15:0]);
                    if (cur_reg[16])
                    begin
                        if (bsz > res_reg.largest_free)
                        begin
                            res_next.largest_free = bsz;
                        end
                    end
                    else
                    begin
                        res_next.used_count = res_reg.used_count + 1'b1;
                        used_sum = acc_bytes_reg + {1'b0, bsz};
                        acc_bytes_next = (used_sum[16] || acc_bytes_reg[16]) ? 17'h1FFFF
                                                                             : used_sum;
                    end
                end
                if (last && have_cur_reg)
                begin
                    res_next.used_bytes = acc_bytes_next[16] ? 16'hFFFF
                                                             : acc_bytes_next[15:0];
                    state_next = S_OUT;
                end
                else
                begin
                    cur_next = rdata; have_cur_next = 1'b1;
                    i_next = i_reg + 1'b1; state_next = S_STAT_RD;
                    // hold have_cur through the read cycle
                end
            end
            S_OUT:
            begin
                rsp.valid = 1'b1;
                if (rsp.ready)
                begin
                    have_cur_next = 1'b0; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign rsp.status         = res_reg.status;
    assign rsp.granted_offset = res_reg.granted_offset;
    assign rsp.used_count     = res_reg.used_count;
    assign rsp.used_bytes     = res_reg.used_bytes;
    assign rsp.largest_free   = res_reg.largest_free;

    `FFA_ASSERT(a_count_range, count_reg >= CNT_W'(1) && count_reg <= CNT_W'(MAX_BLOCKS),
        "block count out of range")
    `FFA_ASSERT(a_ready_idle, !req.ready || state_reg == S_IDLE, "ready outside idle")
    `FFA_ASSERT_NEXT(a_hold_result, rsp.valid && !rsp.ready, rsp.valid && $stable(res_reg),
        "result changed while stalled")
endmodule

FILE: bench/tb_first_fit_block_allocator_unit.sv
// testbench for the first-fit block allocator: a driver and a monitor over the
// request and response channels, checked against an in-bench table predictor
// depends on ffa_pkg, ffa_if and first_fit_block_allocator_unit
`timescale 1ns / 100ps

module tb_first_fit_block_allocator_unit;
    import ffa_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int STALL_LIMIT = 300000;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] req_size;
        logic [15:0] blk_off;
    } heap_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    ffa_req_if req_ch();
    ffa_rsp_if rsp_ch();

    first_fit_block_allocator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    heap_cmd_t   pending_cmds[$];
    result_t     expected_results[$];
    logic [15:0] granted_pool[$];
    int          send_idle_pct = 34;
    int          recv_idle_pct = 48;
    int          error_count = 0;
    int          quiet_cycles = 0;

    // predictor copy of the block table
    logic [15:0] blk_offset[MAX_BLOCKS];
    bit          blk_free[MAX_BLOCKS];
    int          blk_count = 1;
    int          arena_reg = 4096;
    int          arena_latched = 4096;

    function automatic int data_size(int i);
        int s;
        if (i + 1 < blk_count)
            s = int'(blk_offset[i + 1]) - int'(blk_offset[i]) - HEADER_BYTES;
        else
            s = arena_latched - int'(blk_offset[i]);
        return (s < 0) ? 0 : s;
    endfunction

    task automatic drop_block(int i);
        for (int k = i; k + 1 < blk_count; k++)
        begin
            blk_offset[k] = blk_offset[k + 1];
            blk_free[k] = blk_free[k + 1];
        end
        blk_count--;
    endtask

    task automatic predict_heap_op(heap_cmd_t c);
        result_t r;
        int      bs;
        int      lfree;
        int      ubytes;
        int      ucount;
        bit      right_free;
        r = '0;
        if (c.op == OP_INIT)
        begin
            arena_latched = arena_reg;
            blk_offset[0] = HEADER_BYTES;
            blk_free[0] = 1'b1;
            blk_count = 1;
            granted_pool.delete();
        end
        else if (c.op == OP_ALLOC)
        begin
            r.status = ST_NO_FIT;
            for (int i = 0; i < blk_count; i++)
            begin
                if (!blk_free[i])
                    continue;
                bs = data_size(i);
                if (bs < int'(c.req_size))
                    continue;
                if (bs > int'(c.req_size) + HEADER_BYTES && blk_count < MAX_BLOCKS)
                begin
                    for (int k = blk_count; k > i + 1; k--)
                    begin
                        blk_offset[k] = blk_offset[k - 1];
                        blk_free[k] = blk_free[k - 1];
                    end
                    blk_offset[i + 1] = blk_offset[i] + c.req_size + 16'(HEADER_BYTES);
                    blk_free[i + 1] = 1'b1;
                    blk_count++;
                end
                blk_free[i] = 1'b0;
                r.granted_offset = blk_offset[i];
                r.status = ST_OK;
                granted_pool.push_back(blk_offset[i]);
                break;
            end
        end
        else if (c.op == OP_FREE)
        begin
            r.status = ST_NOT_FOUND;
            for (int i = 0; i < blk_count; i++)
            begin
                if (blk_offset[i] != c.blk_off)
                    continue;
                right_free = (i + 1 < blk_count) && blk_free[i + 1];
                if (i == 0 || !blk_free[i - 1])
                begin
                    blk_free[i] = 1'b1;
                    if (right_free)
                        drop_block(i + 1);
                end
                else
                begin
                    if (right_free)
                        drop_block(i + 1);
                    drop_block(i);
                end
                r.status = ST_OK;
                break;
            end
        end
        lfree = 0;
        ubytes = 0;
        ucount = 0;
        for (int i = 0; i < blk_count; i++)
        begin
            bs = data_size(i);
            if (blk_free[i])
            begin
                if (bs > lfree)
                    lfree = bs;
            end
            else
            begin
                ucount++;
                ubytes += bs;
            end
        end
        r.used_count = 13'(ucount);
        r.used_bytes = (ubytes > 65535) ? 16'hFFFF : 16'(ubytes);
        r.largest_free = (lfree > 65535) ? 16'hFFFF : 16'(lfree);
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // driver
    always @(posedge clk)
    begin
        heap_cmd_t c;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                c.op = req_ch.opcode;
                c.req_size = req_ch.request_size;
                c.blk_off = req_ch.block_offset;
                predict_heap_op(c);
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    c = pending_cmds.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.opcode <= c.op;
                    req_ch.request_size <= c.req_size;
                    req_ch.block_offset <= c.blk_off;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("unexpected response beat at %0t", $realtime);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_mismatch("status", rsp_ch.status, want.status);
                    if (rsp_ch.granted_offset !== want.granted_offset)
                        report_mismatch("granted_offset", rsp_ch.granted_offset,
                                        want.granted_offset);
                    if (rsp_ch.used_count !== want.used_count)
                        report_mismatch("used_count", rsp_ch.used_count, want.used_count);
                    if (rsp_ch.used_bytes !== want.used_bytes)
                        report_mismatch("used_bytes", rsp_ch.used_bytes, want.used_bytes);
                    if (rsp_ch.largest_free !== want.largest_free)
                        report_mismatch("largest_free", rsp_ch.largest_free,
                                        want.largest_free);
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_cmd(logic [1:0] op, logic [15:0] sz, logic [15:0] off);
        heap_cmd_t c;
        c.op = op;
        c.req_size = sz;
        c.blk_off = off;
        pending_cmds.push_back(c);
    endtask

    task automatic drain_and_write(logic [15:0] arena);
        wait (pending_cmds.size() == 0 && expected_results.size() == 0 && !req_ch.valid);
        repeat (20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= arena;
        @(posedge clk);
        cfg_we <= 1'b0;
        arena_reg = int'(arena);
    endtask

    // one random command; allocate and free dominate so the table grows and merges
    task automatic push_random_cmd(int arena);
        int          pick;
        int          idx;
        logic [15:0] off;
        pick = $urandom_range(99);
        if (pick < 3)
            push_cmd(OP_INIT, 16'($urandom), 16'($urandom));
        else if (pick < 6)
            push_cmd(OP_NOP, 16'($urandom), 16'($urandom));
        else if (pick < 55)
        begin
            if ($urandom_range(9) == 0)
                push_cmd(OP_ALLOC, 16'($urandom), 16'($urandom));
            else
                push_cmd(OP_ALLOC, 16'($urandom_range(arena / 6)), 16'($urandom));
        end
        else
        begin
            if (granted_pool.size() > 0 && $urandom_range(9) != 0)
            begin
                idx = $urandom_range(granted_pool.size() - 1);
                off = granted_pool[idx];
                // leave some in the pool so frees of free blocks happen
                if ($urandom_range(3) != 0)
                    granted_pool.delete(idx);
            end
            else
                off = 16'($urandom);
            push_cmd(OP_FREE, 16'($urandom), off);
        end
        // one at a time so free offsets come from the current table
        wait (pending_cmds.size() == 0);
        @(posedge clk);
    endtask

    initial
    begin
        cfg_we = 1'b0;
        cfg_wdata = 16'd0;
        req_ch.valid = 1'b0;
        req_ch.opcode = OP_INIT;
        req_ch.request_size = 16'd0;
        req_ch.block_offset = 16'd0;
        rsp_ch.ready = 1'b0;
        blk_offset[0] = 16'(HEADER_BYTES);
        blk_free[0] = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed part on the reset arena
        push_cmd(OP_NOP, 16'hFFFF, 16'hFFFF);
        push_cmd(OP_ALLOC, 16'd0, 16'd0);
        push_cmd(OP_ALLOC, 16'hFFFF, 16'd0);
        push_cmd(OP_ALLOC, 16'd100, 16'd0);
        push_cmd(OP_ALLOC, 16'd200, 16'd0);
        push_cmd(OP_FREE, 16'd0, 16'd160);
        push_cmd(OP_FREE, 16'd0, 16'd160);
        push_cmd(OP_FREE, 16'd0, 16'hFFFF);
        push_cmd(OP_FREE, 16'd0, 16'd32);
        push_cmd(OP_FREE, 16'd0, 16'd16);
        push_cmd(OP_ALLOC, 16'd4070, 16'd0);
        push_cmd(OP_INIT, 16'd0, 16'd0);
        push_cmd(OP_ALLOC, 16'd4064, 16'd0);
        push_cmd(OP_ALLOC, 16'd1, 16'd0);
        push_cmd(OP_FREE, 16'd0, 16'd16);
        push_cmd(OP_ALLOC, 16'd4081, 16'd0);

        // arena shorter than any data: block of size zero
        drain_and_write(16'd16);
        push_cmd(OP_ALLOC, 16'd0, 16'd0);
        push_cmd(OP_INIT, 16'd0, 16'd0);
        push_cmd(OP_ALLOC, 16'd1, 16'd0);
        push_cmd(OP_ALLOC, 16'd0, 16'd0);
        push_cmd(OP_FREE, 16'd0, 16'd16);

        drain_and_write(16'hFFFF);
        push_cmd(OP_INIT, 16'd0, 16'd0);
        push_cmd(OP_ALLOC, 16'hFFEF, 16'd0);
        push_cmd(OP_FREE, 16'd0, 16'd16);
        for (int n = 0; n < 35; n++)
            push_random_cmd(65535);

        drain_and_write(16'd300);
        send_idle_pct = 48;
        recv_idle_pct = 34;
        push_cmd(OP_INIT, 16'd0, 16'd0);
        for (int n = 0; n < 40; n++)
            push_random_cmd(300);

        drain_and_write(16'd4096);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_cmd(OP_INIT, 16'd0, 16'd0);
        for (int n = 0; n < 40; n++)
            push_random_cmd(4096);

        wait (pending_cmds.size() == 0 && expected_results.size() == 0 && !req_ch.valid);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
